>>> rtl/lea128_pkg.sv
package lea128_pkg;

    localparam int WORD_W          = 32;
    localparam int ROUND_COUNT_DEF = 24;
    localparam int ROUND_IDX_W     = 5;
    localparam int CFG_IDX_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = CFG_IDX_W'(3);

    typedef logic [3:0][WORD_W-1:0] word4_t;

    // element 0 is the first delta
    localparam word4_t LEA_DELTA = {
        32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
    };

    typedef struct packed {
        word4_t x;    // block words
        word4_t t;    // key words for the round the next stage performs
    } lea128_stage_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [ROUND_IDX_W-1:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    // key words after the update of round r
    function automatic word4_t key_update(input word4_t t,
                                          input logic [ROUND_IDX_W-1:0] r);
        logic [WORD_W-1:0] d;
        word4_t            tn;
        d     = rotl32(LEA_DELTA[r[1:0]], r);
        tn[0] = rotl32(t[0] + d, 5'd1);
        tn[1] = rotl32(t[1] + rotl32(d, 5'd1), 5'd3);
        tn[2] = rotl32(t[2] + rotl32(d, 5'd2), 5'd6);
        tn[3] = rotl32(t[3] + rotl32(d, 5'd3), 5'd11);
        return tn;
    endfunction

    // add-rotate-xor round followed by the word rotation
    function automatic word4_t arx_round(input word4_t x, input word4_t t);
        word4_t xn;
        xn[0] = rotl32((x[0] ^ t[0]) + (x[1] ^ t[1]), 5'd9);
        xn[1] = rotl32((x[1] ^ t[2]) + (x[2] ^ t[1]), 5'd27);
        xn[2] = rotl32((x[2] ^ t[3]) + (x[3] ^ t[1]), 5'd29);
        xn[3] = x[0];
        return xn;
    endfunction

endpackage

>>> rtl/lea128_entry.sv
module lea128_entry
    import lea128_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  word4_t        key,
    input  logic          in_valid,
    output logic          in_ready,
    input  word4_t        in_block,
    output logic          out_valid,
    input  logic          out_ready,
    output lea128_stage_t out_data
);

    logic          valid_reg;
    lea128_stage_t data_reg;
    lea128_stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.x = in_block;
        // key words for round 0, one add ahead of the first round stage
        data_next.t = key_update(key, ROUND_IDX_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/lea128_round.sv
module lea128_round
    import lea128_pkg::*;
#(
    parameter int ROUND = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lea128_stage_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output lea128_stage_t out_data
);

    localparam logic [ROUND_IDX_W-1:0] NEXT_ROUND = ROUND_IDX_W'((ROUND + 1) % 32);

    logic          valid_reg;
    lea128_stage_t data_reg;
    lea128_stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.x = arx_round(in_data.x, in_data.t);
        // schedule runs one round ahead of the data path
        data_next.t = key_update(in_data.t, NEXT_ROUND);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/lea128_block_encrypt_unit.sv
// LEA-128 block encryption, one block per cycle while the receiver does not stall.
// Input channel s_*: four plaintext words, word 0 first, with s_valid/s_ready.
// Result channel m_*: four ciphertext words with m_valid/m_ready.
// Key: four 32-bit words written through cfg_valid/cfg_ready, cfg_index
// (0 to 3 select key words, other indexes are ignored) and cfg_data.
// cfg_ready is always high; write the key only while no item is in flight.
// Each round is one register stage, with the key schedule carried along
// the pipeline one round ahead of the data, after an entry stage that
// registers the block and the first round keys.
// Each block passes the entry stage and then every round stage before m_valid.
// Throughput: one item per cycle unless m_ready stalls, set by the one-round-per-stage pipeline.
// Reset clears the key to zero and empties the pipeline.
// When the receiver stalls, every stage holds its item; stages upstream of
// an empty stage keep moving, so s_ready drops only once the whole pipeline
// is full.
module lea128_block_encrypt_unit
    import lea128_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_plain_word0,
    input  logic [WORD_W-1:0]    s_plain_word1,
    input  logic [WORD_W-1:0]    s_plain_word2,
    input  logic [WORD_W-1:0]    s_plain_word3,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_W-1:0]    m_cipher_word0,
    output logic [WORD_W-1:0]    m_cipher_word1,
    output logic [WORD_W-1:0]    m_cipher_word2,
    output logic [WORD_W-1:0]    m_cipher_word3
);

    localparam int CNT_W = $clog2(ROUND_COUNT + 2);

    word4_t               key_reg;
    word4_t               in_block;
    logic [ROUND_COUNT:0] stage_valid;
    logic [ROUND_COUNT:0] stage_ready;
    lea128_stage_t        stage_data [ROUND_COUNT+1];
    logic [CNT_W-1:0]     inflight_reg;
    logic [CNT_W-1:0]     inflight_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_WORD0: key_reg[0] <= cfg_data;
                CFG_KEY_WORD1: key_reg[1] <= cfg_data;
                CFG_KEY_WORD2: key_reg[2] <= cfg_data;
                CFG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_block = {s_plain_word3, s_plain_word2, s_plain_word1, s_plain_word0};

    lea128_entry u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key       (key_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_block  (in_block),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        lea128_round #(
            .ROUND (r)
        ) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[r]),
            .in_ready  (stage_ready[r]),
            .in_data   (stage_data[r]),
            .out_valid (stage_valid[r+1]),
            .out_ready (stage_ready[r+1]),
            .out_data  (stage_data[r+1])
        );
    end

    assign stage_ready[ROUND_COUNT] = m_ready;
    assign m_valid        = stage_valid[ROUND_COUNT];
    assign m_cipher_word0 = stage_data[ROUND_COUNT].x[0];
    assign m_cipher_word1 = stage_data[ROUND_COUNT].x[1];
    assign m_cipher_word2 = stage_data[ROUND_COUNT].x[2];
    assign m_cipher_word3 = stage_data[ROUND_COUNT].x[3];

    // item count in flight, for checking only
    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready) begin
            inflight_next = inflight_next + CNT_W'(1);
        end
        if (m_valid && m_ready) begin
            inflight_next = inflight_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_inflight_matches_stages: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(inflight_reg) == $countones(stage_valid))
        else $error("items in flight differ from occupied stages");

    a_ready_when_entry_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !stage_valid[0] |-> s_ready)
        else $error("input stalled with a free entry stage");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && stage_valid == '0))
        else $error("pipeline not empty after reset");

    a_no_result_from_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg == '0) |-> !m_valid)
        else $error("result shown with no item in flight");

endmodule
